// File: sv/r2fc_pkg.sv
// shared types and constants for the radix-2 combine stage
package r2fc_pkg;

   // fixed field widths
   localparam int WORD_W      = 32;
   localparam int PART_W      = 16;
   localparam int POSITION_W  = 13;
   localparam int HALF_W      = 13;
   localparam int STEP_W      = 3;
   localparam int FUNC_W      = 2;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 13;

   // width of address arithmetic before wrapping (k * step peaks at 57337)
   localparam int ADDR_CALC_W = 16;

   // register reset values
   localparam logic [HALF_W-1:0] HALF_RESET = 13'd4096;
   localparam logic [STEP_W-1:0] STEP_RESET = 3'd1;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_HALF_LENGTH  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TWIDDLE_STEP = 2'd1;

   // item functions
   typedef enum logic [FUNC_W-1:0] {
      FUNC_TWIDDLE_WRITE = 2'd0,
      FUNC_DATA_WRITE    = 2'd1,
      FUNC_BUTTERFLY     = 2'd2
   } func_type;

   // control travelling alongside each pipeline stage
   typedef struct packed {
      logic     valid;
      func_type func;
   } stage_ctl_type;

endpackage

// File: sv/r2fc_ram.sv
// generic single-write, single-read ram with registered read data
module r2fc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8192,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/r2fc_addr_mod.sv
// two-stage address wrap: x modulo a constant depth by reciprocal multiply
module r2fc_addr_mod #(
   parameter int DEPTH = 8192,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                           clock,
   input  logic                           en,
   input  logic [r2fc_pkg::ADDR_CALC_W-1:0] x,
   output logic [AW-1:0]                  addr
);
   import r2fc_pkg::*;

   // floor(2^31 / depth): quotient estimate is exact or one short
   localparam logic [31:0] RECIP = 32'((64'd1 << 31) / DEPTH);
   localparam int          RW    = ADDR_CALC_W + 18;
   localparam logic [RW-1:0] DEPTH_W = RW'(DEPTH);

   logic [ADDR_CALC_W+31:0] prod;
   logic [ADDR_CALC_W-1:0]  q_in, q_ff;
   logic [ADDR_CALC_W-1:0]  x_ff;
   logic [RW-1:0]           rem_raw;
   logic [RW-1:0]           rem_fix;
   logic [AW-1:0]           addr_in, addr_ff;

   // quotient estimate
   assign prod = (ADDR_CALC_W + 32)'(x) * (ADDR_CALC_W + 32)'(RECIP);
   assign q_in = prod[ADDR_CALC_W+30:31];

   // remainder with one correction step
   always_comb begin
      rem_raw = RW'(x_ff) - RW'(q_ff) * DEPTH_W;
      rem_fix = (rem_raw >= DEPTH_W) ? rem_raw - DEPTH_W : rem_raw;
      addr_in = AW'(rem_fix);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         q_ff    <= q_in;
         x_ff    <= x;
         addr_ff <= addr_in;
      end
   end

   assign addr = addr_ff;

endmodule

// File: sv/r2fc_bfly.sv
// two-stage q15 butterfly: twiddle product, then halved sum and difference
module r2fc_bfly (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       en,
   input  r2fc_pkg::stage_ctl_type    ctl,
   input  logic [r2fc_pkg::WORD_W-1:0] twiddle,
   input  logic [r2fc_pkg::WORD_W-1:0] even,
   input  logic [r2fc_pkg::WORD_W-1:0] odd,
   output logic                       out_valid,
   output logic [r2fc_pkg::WORD_W-1:0] sum_word,
   output logic [r2fc_pkg::WORD_W-1:0] difference_word
);
   import r2fc_pkg::*;

   logic signed [PART_W-1:0]   tw_re, tw_im, od_re, od_im;
   logic signed [2*PART_W-1:0] rr_in, ii_in, ri_in, ir_in;
   logic signed [2*PART_W-1:0] rr_ff, ii_ff, ri_ff, ir_ff;
   logic [WORD_W-1:0]          even_a_ff, even_b_ff;
   logic                       valid_a_ff, valid_b_ff;
   logic [2*PART_W-1:0]        re_sum, im_sum;
   logic [PART_W-1:0]          t_re_in, t_im_in, t_re_ff, t_im_ff;
   logic [PART_W-1:0]          neg_re, neg_im;
   logic [PART_W:0]            s_re, s_im, d_re, d_im;

   // partial products of twiddle times odd operand
   always_comb begin
      tw_re = signed'(twiddle[WORD_W-1:PART_W]);
      tw_im = signed'(twiddle[PART_W-1:0]);
      od_re = signed'(odd[WORD_W-1:PART_W]);
      od_im = signed'(odd[PART_W-1:0]);
      rr_in = tw_re * od_re;
      ii_in = tw_im * od_im;
      ri_in = tw_re * od_im;
      ir_in = tw_im * od_re;
   end

   // wrapping part sums, scaled back to q15
   always_comb begin
      re_sum  = rr_ff - ii_ff;
      im_sum  = ri_ff + ir_ff;
      t_re_in = re_sum[2*PART_W-2:PART_W-1];
      t_im_in = im_sum[2*PART_W-2:PART_W-1];
   end

   // pipeline registers
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
         valid_b_ff <= 1'b0;
      end else if (en) begin
         valid_a_ff <= ctl.valid && (ctl.func == FUNC_BUTTERFLY);
         valid_b_ff <= valid_a_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rr_ff     <= rr_in;
         ii_ff     <= ii_in;
         ri_ff     <= ri_in;
         ir_ff     <= ir_in;
         even_a_ff <= even;
         even_b_ff <= even_a_ff;
         t_re_ff   <= t_re_in;
         t_im_ff   <= t_im_in;
      end
   end

   // halved sum and difference, negation wraps in 16 bits
   always_comb begin
      neg_re = PART_W'(0) - t_re_ff;
      neg_im = PART_W'(0) - t_im_ff;
      s_re = {even_b_ff[WORD_W-1], even_b_ff[WORD_W-1:PART_W]} + {t_re_ff[PART_W-1], t_re_ff};
      s_im = {even_b_ff[PART_W-1], even_b_ff[PART_W-1:0]} + {t_im_ff[PART_W-1], t_im_ff};
      d_re = {even_b_ff[WORD_W-1], even_b_ff[WORD_W-1:PART_W]} + {neg_re[PART_W-1], neg_re};
      d_im = {even_b_ff[PART_W-1], even_b_ff[PART_W-1:0]} + {neg_im[PART_W-1], neg_im};
   end

   assign out_valid       = valid_b_ff;
   assign sum_word        = {s_re[PART_W:1], s_im[PART_W:1]};
   assign difference_word = {d_re[PART_W:1], d_im[PART_W:1]};

endmodule

// File: sv/radix2_fft_combine_stage_unit.sv
// top level: radix-2 dit combine stage over data and twiddle rams
//
// Accepts one word per cycle of any kind (twiddle load, data load, butterfly)
// and returns butterfly results at one result per cycle, both while the
// output is not stalled. Stages: one input register, address wrapping (k,
// k + half_length and k * twiddle_step modulo each ram depth, by reciprocal
// multiply), one ram read, two butterfly stages and the output register.
// All ram writes and reads issue at the same pipeline stage in item order, so
// a butterfly always sees every load accepted before it. The data store is
// kept as two identical rams so both operands are read in the same cycle. A
// stalled output holds the whole pipeline; req_stall follows it. The ram
// contents are undefined until loaded; no clearing pass is run.
module radix2_fft_combine_stage_unit #(
   parameter int DATA_DEPTH    = 8192,
   parameter int TWIDDLE_DEPTH = 4096
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [r2fc_pkg::FUNC_W-1:0]       req_func,
   input  logic [r2fc_pkg::POSITION_W-1:0]   req_position,
   input  logic [r2fc_pkg::WORD_W-1:0]       req_word,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [r2fc_pkg::WORD_W-1:0]       rsp_sum_word,
   output logic [r2fc_pkg::WORD_W-1:0]       rsp_difference_word,
   input  logic                              csr_write,
   input  logic [r2fc_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [r2fc_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import r2fc_pkg::*;

   localparam int DAW = (DATA_DEPTH > 1) ? $clog2(DATA_DEPTH) : 1;
   localparam int TAW = (TWIDDLE_DEPTH > 1) ? $clog2(TWIDDLE_DEPTH) : 1;

   logic                   adv;
   logic                   accept;
   logic [HALF_W-1:0]      half_ff;
   logic [STEP_W-1:0]      step_ff;
   stage_ctl_type          ctl0_in, ctl0_ff, ctl1_ff, ctl2_ff, ctl3_ff;
   logic [WORD_W-1:0]      word0_ff, word1_ff, word2_ff;
   logic [ADDR_CALC_W-1:0] xe_in, xo_in, xt_in;
   logic [ADDR_CALC_W-1:0] xe_ff, xo_ff, xt_ff;
   logic [DAW-1:0]         even_addr, odd_addr;
   logic [TAW-1:0]         tw_addr;
   logic                   data_wr_en, tw_wr_en;
   logic [WORD_W-1:0]      even_word, odd_word, tw_word;
   logic                   bfly_valid;
   logic [WORD_W-1:0]      bfly_sum, bfly_diff;
   logic                   rsp_valid_ff;
   logic [WORD_W-1:0]      rsp_sum_word_ff, rsp_difference_word_ff;

   // pipeline moves unless a result is waiting on a stalled output
   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !adv;
   assign accept    = req_valid && adv;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         half_ff <= HALF_RESET;
         step_ff <= STEP_RESET;
      end else if (csr_write) begin
         case (csr_index)
            CSR_HALF_LENGTH:  half_ff <= csr_wdata[HALF_W-1:0];
            CSR_TWIDDLE_STEP: step_ff <= csr_wdata[STEP_W-1:0];
            default: ;
         endcase
      end
   end

   // raw addresses of the incoming word
   always_comb begin
      ctl0_in.valid = accept;
      ctl0_in.func  = func_type'(req_func);
      xe_in = ADDR_CALC_W'(req_position);
      xo_in = ADDR_CALC_W'(req_position) + ADDR_CALC_W'(half_ff);
      if (ctl0_in.func == FUNC_TWIDDLE_WRITE) begin
         xt_in = ADDR_CALC_W'(req_position);
      end else begin
         xt_in = ADDR_CALC_W'(req_position) * ADDR_CALC_W'(step_ff);
      end
   end

   // stage control
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl0_ff <= '0;
         ctl1_ff <= '0;
         ctl2_ff <= '0;
         ctl3_ff <= '0;
      end else if (adv) begin
         ctl0_ff <= ctl0_in;
         ctl1_ff <= ctl0_ff;
         ctl2_ff <= ctl1_ff;
         ctl3_ff <= ctl2_ff;
      end
   end

   // stage payload
   always_ff @(posedge clock) begin
      if (adv) begin
         word0_ff <= req_word;
         word1_ff <= word0_ff;
         word2_ff <= word1_ff;
         xe_ff    <= xe_in;
         xo_ff    <= xo_in;
         xt_ff    <= xt_in;
      end
   end

   // address wrapping
   r2fc_addr_mod #(.DEPTH(DATA_DEPTH), .AW(DAW)) u_even_mod (
      .clock (clock),
      .en    (adv),
      .x     (xe_ff),
      .addr  (even_addr)
   );

   r2fc_addr_mod #(.DEPTH(DATA_DEPTH), .AW(DAW)) u_odd_mod (
      .clock (clock),
      .en    (adv),
      .x     (xo_ff),
      .addr  (odd_addr)
   );

   r2fc_addr_mod #(.DEPTH(TWIDDLE_DEPTH), .AW(TAW)) u_tw_mod (
      .clock (clock),
      .en    (adv),
      .x     (xt_ff),
      .addr  (tw_addr)
   );

   // ram writes issue at the same stage as butterfly reads
   assign data_wr_en = adv && ctl2_ff.valid && (ctl2_ff.func == FUNC_DATA_WRITE);
   assign tw_wr_en   = adv && ctl2_ff.valid && (ctl2_ff.func == FUNC_TWIDDLE_WRITE);

   // data store, two copies for the even and odd reads
   r2fc_ram #(.WIDTH(WORD_W), .DEPTH(DATA_DEPTH), .AW(DAW)) u_data_even (
      .clock   (clock),
      .wr_en   (data_wr_en),
      .wr_addr (even_addr),
      .wr_data (word2_ff),
      .rd_en   (adv),
      .rd_addr (even_addr),
      .rd_data (even_word)
   );

   r2fc_ram #(.WIDTH(WORD_W), .DEPTH(DATA_DEPTH), .AW(DAW)) u_data_odd (
      .clock   (clock),
      .wr_en   (data_wr_en),
      .wr_addr (even_addr),
      .wr_data (word2_ff),
      .rd_en   (adv),
      .rd_addr (odd_addr),
      .rd_data (odd_word)
   );

   // twiddle store
   r2fc_ram #(.WIDTH(WORD_W), .DEPTH(TWIDDLE_DEPTH), .AW(TAW)) u_twiddle (
      .clock   (clock),
      .wr_en   (tw_wr_en),
      .wr_addr (tw_addr),
      .wr_data (word2_ff),
      .rd_en   (adv),
      .rd_addr (tw_addr),
      .rd_data (tw_word)
   );

   // butterfly arithmetic
   r2fc_bfly u_bfly (
      .clock           (clock),
      .reset           (reset),
      .en              (adv),
      .ctl             (ctl3_ff),
      .twiddle         (tw_word),
      .even            (even_word),
      .odd             (odd_word),
      .out_valid       (bfly_valid),
      .sum_word        (bfly_sum),
      .difference_word (bfly_diff)
   );

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= bfly_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv && bfly_valid) begin
         rsp_sum_word_ff        <= bfly_sum;
         rsp_difference_word_ff <= bfly_diff;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_sum_word        = rsp_sum_word_ff;
   assign rsp_difference_word = rsp_difference_word_ff;

   // an accepted word enters the first stage
   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      accept |=> ctl0_ff.valid)
      else $error("accepted word lost at first stage");

   // the ram stage holds while the output is stalled
   a_stage_holds: assert property (@(posedge clock) disable iff (reset)
      !adv |=> (ctl3_ff == $past(ctl3_ff)))
      else $error("ram stage moved during stall");

   // a finished butterfly reaches the output register
   a_result_lands: assert property (@(posedge clock) disable iff (reset)
      (adv && bfly_valid) |=> rsp_valid_ff)
      else $error("butterfly result dropped");

endmodule
